>>> hdl/delta_timer_queue_top_assert.svh
// Assertion helpers for the timer queue.
`ifndef DELTA_TIMER_QUEUE_TOP_ASSERT_SVH
`define DELTA_TIMER_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DTQ_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DTQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dtq_pkg.sv
package dtq_pkg;

    localparam int ID_W    = 16;
    localparam int DELTA_W = 24;
    localparam int TICK_W  = 16;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int SAT_W   = 40;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [SAT_W-1:0]   sat_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        delta_t          delta;
    } entry_t;

    localparam sat_t DELTA_MAX = sat_t'((64'sd1 <<< (DELTA_W - 1)) - 64'sd1);
    localparam sat_t DELTA_MIN = sat_t'(-(64'sd1 <<< (DELTA_W - 1)));

    // Clamp a wide signed value to the delta range.
    function automatic delta_t sat_delta(input sat_t v);
        delta_t r;
        if (v > DELTA_MAX)
        begin
            r = DELTA_MAX[DELTA_W-1:0];
        end
        else if (v < DELTA_MIN)
        begin
            r = DELTA_MIN[DELTA_W-1:0];
        end
        else
        begin
            r = v[DELTA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/dtq_mem.sv
module dtq_mem
    import dtq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  entry_t                   wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output entry_t                   rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/delta_timer_queue_top.sv
// Delta-list timer queue. Entries live in one single-port-write, registered-read
// memory and every operation is a sequence of read/modify/write steps on it, one
// entry per cycle. Add, unused command codes and any rejected command (full,
// empty) finish in the accept step. Tick reads the head and writes back its
// decremented delta while it stays positive, else the head expires. Cancel is
// accepted, then examines entries in order up to the match, then moves each
// entry behind it down; a miss examines every entry. Tick with expiry removes
// the head the same way. Memory contents need no clearing after reset: only
// entries below the fill count are ever used. A running sum of stored deltas is
// kept in a register so an add never walks the list.
module delta_timer_queue_top
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [ID_W-1:0]   timer_id,
    input  logic [TICK_W-1:0] tick_count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [ID_W-1:0]   expired_id
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = DELTA_W + AW + 1;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_TICK,
        S_FOLD,
        S_SHIFT
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    sum_t              sum_reg, sum_next;
    logic [CW-1:0]     idx_reg, idx_next;
    delta_t            dpos_reg, dpos_next;
    logic [ID_W-1:0]   key_reg, key_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_expired_reg, out_expired_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_inc2;
    delta_t        add_delta;
    delta_t        tick_delta;
    delta_t        fold_delta;

    dtq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_inc2 = idx_reg + CW'(2);

    assign add_delta  = sat_delta(sat_t'($signed({1'b0, tick_count})) - sat_t'(sum_reg));
    assign tick_delta = sat_delta(sat_t'(mem_rdata.delta) - sat_t'(1));
    assign fold_delta = sat_delta(sat_t'(mem_rdata.delta) + sat_t'(dpos_reg));

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        idx_next         = idx_reg;
        dpos_next        = dpos_reg;
        key_next         = key_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_expired_next = out_expired_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = mem_rdata;
        mem_raddr        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    out_status_next  = ST_OK;
                    out_expired_next = '0;
                    case (cmd)
                        CMD_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = count_reg[AW-1:0];
                                mem_wdata.id    = timer_id;
                                mem_wdata.delta = add_delta;
                                sum_next        = sum_reg + sum_t'(add_delta);
                                count_next      = count_reg + CW'(1);
                            end
                        end
                        CMD_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                key_next   = timer_id;
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_TICK;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // read one ahead so a match finds its successor already on the bus
                mem_raddr = idx_inc[AW-1:0];
                if (mem_rdata.id == key_reg)
                begin
                    dpos_next = mem_rdata.delta;
                    if (idx_inc < count_reg)
                    begin
                        state_next = S_FOLD;
                    end
                    else
                    begin
                        sum_next       = sum_reg - sum_t'(mem_rdata.delta);
                        count_next     = count_reg - CW'(1);
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    out_status_next = ST_NOT_FOUND;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            S_TICK:
            begin
                mem_raddr = AW'(1);
                if (tick_delta > delta_t'(0))
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = '0;
                    mem_wdata.delta = tick_delta;
                    sum_next        = sum_reg - sum_t'(1);
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    out_status_next  = ST_EXPIRED;
                    out_expired_next = mem_rdata.id;
                    dpos_next        = tick_delta;
                    idx_next         = '0;
                    if (count_reg > CW'(1))
                    begin
                        sum_next   = sum_reg + sum_t'(tick_delta) - sum_t'(mem_rdata.delta);
                        state_next = S_FOLD;
                    end
                    else
                    begin
                        sum_next       = sum_reg - sum_t'(mem_rdata.delta);
                        count_next     = count_reg - CW'(1);
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end

            S_FOLD:
            begin
                // successor takes the removed slot with the folded delta
                mem_we          = 1'b1;
                mem_waddr       = idx_reg[AW-1:0];
                mem_wdata.delta = fold_delta;
                sum_next        = sum_reg + sum_t'(fold_delta) - sum_t'(dpos_reg)
                                  - sum_t'(mem_rdata.delta);
                mem_raddr       = idx_inc2[AW-1:0];
                if (idx_inc2 < count_reg)
                begin
                    idx_next   = idx_inc2;
                    state_next = S_SHIFT;
                end
                else
                begin
                    count_next     = count_reg - CW'(1);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg - CW'(1));
                mem_raddr = idx_inc[AW-1:0];
                if (idx_inc < count_reg)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    count_next     = count_reg - CW'(1);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        dpos_reg        <= dpos_next;
        key_reg         <= key_next;
        out_status_reg  <= out_status_next;
        out_expired_reg <= out_expired_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign expired_id = out_expired_reg;

`include "delta_timer_queue_top_assert.svh"

    `DTQ_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(QUEUE_DEPTH),
        "fill count overflow")
    `DTQ_ASSERT_NOW(a_empty_sum, count_reg == '0, sum_reg == '0,
        "delta sum nonzero when empty")
    `DTQ_ASSERT_NOW(a_busy_slot_free, state_reg != S_IDLE, !out_valid_reg,
        "result pending mid-operation")
    `DTQ_ASSERT_NEXT(a_add_grows,
        in_valid && in_ready && cmd == CMD_ADD && count_reg != CW'(QUEUE_DEPTH),
        count_reg == $past(count_reg) + CW'(1), "add did not grow queue")

endmodule
